FILE: hdl/bpom_pkg.sv
package bpom_pkg;

	localparam int DEF_MAX_BOXES  = 64;
	localparam int DEF_COORD_BITS = 11;
	localparam int AXES           = 3;
	localparam int IDX_W          = 6;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_OVF
	} bpom_state_t;

endpackage

FILE: hdl/box_pair_overlap_matrix_top.sv
// Channel  Direction  Handshake          Payload
// in       receive    in_valid/in_stall  x/y/z_low, x/y/z_high, last_box
// out      send       out_valid/out_stall earlier_index, new_index, overlaps,
//                                        overflow, last_of_run
// A stored box k gives k+1 results, one per cycle while out_stall is low.
// The rate is set by the single read port of the box memory that feeds the compare unit.
// A box that arrives with the store full is not stored and gives one result, flagged as overflow.
// Reset clears the sequencer, the box count and the valid flags; stored boxes stay undefined.
// A stall on the output freezes the read stage and the output register together.
module box_pair_overlap_matrix_top #(
	parameter int MAX_BOXES  = bpom_pkg::DEF_MAX_BOXES,
	parameter int COORD_BITS = bpom_pkg::DEF_COORD_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_BITS-1:0]  x_low,
	input  logic signed [COORD_BITS-1:0]  x_high,
	input  logic signed [COORD_BITS-1:0]  y_low,
	input  logic signed [COORD_BITS-1:0]  y_high,
	input  logic signed [COORD_BITS-1:0]  z_low,
	input  logic signed [COORD_BITS-1:0]  z_high,
	input  logic                          last_box,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bpom_pkg::IDX_W-1:0]    earlier_index,
	output logic [bpom_pkg::IDX_W-1:0]    new_index,
	output logic                          overlaps,
	output logic                          overflow,
	output logic                          last_of_run
);
	import bpom_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CW = $clog2(MAX_BOXES + 1);

	bpom_state_t state_q, state_nxt;

	logic [CW-1:0] box_cnt_q;
	logic [IW-1:0] k_q, j_q, j_s1;
	logic          valid_s1, last_s1;
	logic          out_valid_q;
	logic          full, accept, adv, issue, load_ovf;

	logic signed [CB-1:0] lo [AXES];
	logic signed [CB-1:0] hi [AXES];
	logic [AXES-1:0][CB-1:0] c_in, h_in;
	logic [AXES-1:0][CB-1:0] c_new_q, h_new_q;
	logic [AXES-1:0][CB-1:0] c_rd_s1, h_rd_s1;
	logic [AXES-1:0][CB-1:0] c_mem [MAX_BOXES];
	logic [AXES-1:0][CB-1:0] h_mem [MAX_BOXES];
	logic [AXES-1:0] axis_ok;

	logic [IW+IDX_W-1:0] j_ext, k_ext;

	assign lo[0] = x_low;
	assign hi[0] = x_high;
	assign lo[1] = y_low;
	assign hi[1] = y_high;
	assign lo[2] = z_low;
	assign hi[2] = z_high;

	// Center and half-extent per axis, halved with truncation toward zero.
	for (genvar a = 0; a < AXES; a++) begin : g_axis
		logic signed [CB:0] sum, dif, sum_r, dif_r;
		assign sum   = {lo[a][CB-1], lo[a]} + {hi[a][CB-1], hi[a]};
		assign dif   = {hi[a][CB-1], hi[a]} - {lo[a][CB-1], lo[a]};
		assign sum_r = sum + {{CB{1'b0}}, sum[CB]};
		assign dif_r = dif + {{CB{1'b0}}, dif[CB]};
		assign c_in[a] = sum_r[CB:1];
		assign h_in[a] = dif_r[CB:1];
	end

	assign full     = (box_cnt_q == CW'(MAX_BOXES));
	assign adv      = !out_valid_q || !out_stall;
	assign accept   = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = full ? ST_OVF : ST_RUN;
				end
			end
			ST_RUN: begin
				if (adv && (j_q == k_q)) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (adv) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_OVF: begin
				if (adv) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall = (state_q != ST_IDLE);
		issue    = (state_q == ST_RUN) && adv;
		load_ovf = (state_q == ST_OVF) && adv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			box_cnt_q   <= '0;
			j_q         <= '0;
			k_q         <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				j_q <= '0;
				if (full) begin
					if (last_box) begin
						box_cnt_q <= '0;
					end
				end else begin
					k_q       <= box_cnt_q[IW-1:0];
					box_cnt_q <= last_box ? '0 : box_cnt_q + CW'(1);
				end
			end else if (issue && (j_q != k_q)) begin
				j_q <= j_q + IW'(1);
			end
			if (adv) begin
				valid_s1    <= issue;
				out_valid_q <= valid_s1 || load_ovf;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !full) begin
			c_mem[box_cnt_q[IW-1:0]] <= c_in;
			h_mem[box_cnt_q[IW-1:0]] <= h_in;
			c_new_q <= c_in;
			h_new_q <= h_in;
		end
		if (issue) begin
			c_rd_s1 <= c_mem[j_q];
			h_rd_s1 <= h_mem[j_q];
			j_s1    <= j_q;
			last_s1 <= (j_q == k_q);
		end
	end

	always_comb begin
		logic signed [CB:0] dc, ad, hs;
		for (int a = 0; a < AXES; a++) begin
			dc = {c_rd_s1[a][CB-1], c_rd_s1[a]} - {c_new_q[a][CB-1], c_new_q[a]};
			ad = dc[CB] ? -dc : dc;
			hs = {h_rd_s1[a][CB-1], h_rd_s1[a]} + {h_new_q[a][CB-1], h_new_q[a]};
			axis_ok[a] = (ad <= hs);
		end
	end

	assign j_ext = {{IDX_W{1'b0}}, j_s1};
	assign k_ext = {{IDX_W{1'b0}}, k_q};

	always_ff @(posedge clk) begin
		if (adv) begin
			if (load_ovf) begin
				earlier_index <= '0;
				new_index     <= '0;
				overlaps      <= 1'b0;
				overflow      <= 1'b1;
				last_of_run   <= 1'b1;
			end else begin
				earlier_index <= j_ext[IDX_W-1:0];
				new_index     <= k_ext[IDX_W-1:0];
				overlaps      <= &axis_ok;
				overflow      <= 1'b0;
				last_of_run   <= last_s1;
			end
		end
	end

endmodule
